// File: rtl/sct_pkg.sv
// Shared types, constants and helpers for the sparse chunked tile store.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  // Default build-time sizes
  localparam int CHUNK_SHIFT_DEF = 4;
  localparam int MAX_CHUNKS_DEF  = 4096;
  localparam int POOL_SLOTS_DEF  = 64;
  localparam int TILE_BITS_DEF   = 16;

  // Field and datapath widths
  localparam int COORD_W = 32;
  localparam int VALUE_W = 16;
  localparam int CNT_W   = 13;
  localparam int PROD_W  = 2 * CNT_W;
  localparam int IDX_W   = 40;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_CNT_X = 2'd0;
  localparam logic [1:0] REG_CNT_Y = 2'd1;
  localparam logic [1:0] REG_CNT_Z = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0] CNT_X_RST = 13'd16;
  localparam logic [CNT_W-1:0] CNT_Y_RST = 13'd16;
  localparam logic [CNT_W-1:0] CNT_Z_RST = 13'd1;

  // Item actions
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Tile values that mean empty, and the fill value of a fresh chunk
  localparam logic [VALUE_W-1:0] EMPTY_VAL_A = 16'd1;
  localparam logic [VALUE_W-1:0] EMPTY_VAL_B = 16'd3;
  localparam logic [VALUE_W-1:0] EMPTY_VAL_C = 16'd4;
  localparam int FILL_VAL = 1;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] abs_x;
    logic [COORD_W-1:0] abs_y;
    logic [COORD_W-1:0] abs_z;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] tile_value;
    logic               is_empty;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt_x;
    logic [CNT_W-1:0] cnt_y;
    logic [CNT_W-1:0] cnt_z;
  } cfg_t;

  function automatic logic empty_flag(input logic [VALUE_W-1:0] v);
    return (v == EMPTY_VAL_A) || (v == EMPTY_VAL_B) || (v == EMPTY_VAL_C);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sparse_chunked_tile_store.sv
// Top level: request sequencer over the chunk table and tile pool memories.
//
// Each item reads or writes one tile at absolute x, y, z. The chunk is
// range-checked against the configured counts and flattened to an index; the
// chunk table gives its pool slot, and the first write to a chunk takes the
// next free slot and fills its 2^(2*CHUNK_SHIFT) tiles with 1. Exactly one
// result comes out per item on done_o for a single cycle; it cannot be held
// off, so capture it when the strobe is high. Each item steps through S_MUL
// (range check), S_IDX (index) and S_LOOK, where an out-of-range chunk ends.
// Others read the chunk table in S_TBL, where a read of an unallocated chunk,
// a write to an allocated chunk or a dropped write ends; a read of an
// allocated chunk adds the tile pool read in S_POOL, and a write that
// allocates adds S_FILL, the fill pass over the tile pool write port. busy
// is high while an item is in flight; the next item can start in the cycle
// of the strobe. After reset busy stays high while the chunk table is swept
// to unallocated; register writes are taken then.
`timescale 1ns / 1ps
`default_nettype none

module sparse_chunked_tile_store #(
  parameter int CHUNK_SHIFT = sct_pkg::CHUNK_SHIFT_DEF,
  parameter int MAX_CHUNKS  = sct_pkg::MAX_CHUNKS_DEF,
  parameter int POOL_SLOTS  = sct_pkg::POOL_SLOTS_DEF,
  parameter int TILE_BITS   = sct_pkg::TILE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire sct_pkg::req_t               req_i,
  output logic                             done_o,
  output sct_pkg::rsp_t                    rsp_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sct_pkg::APB_AW-1:0]  paddr,
  input  wire logic [sct_pkg::APB_DW-1:0]  pwdata,
  output logic      [sct_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int CIW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int SW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int NFW   = $clog2(POOL_SLOTS + 1);
  localparam int TW    = 2 * CHUNK_SHIFT;
  localparam int TILES = 1 << TW;
  localparam int PAW   = SW + TW;
  localparam int PDEPTH = POOL_SLOTS * TILES;
  localparam int CNT_W = sct_pkg::CNT_W;
  localparam int IDX_W = sct_pkg::IDX_W;
  localparam int PROD_W = sct_pkg::PROD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_IDX,
    S_LOOK,
    S_TBL,
    S_POOL,
    S_FILL
  } state_e;

  state_e              state_q, state_d;
  sct_pkg::req_t       req_q, req_d;
  logic                range_q, range_d;
  logic [PROD_W-1:0]   prod_xy_q, prod_xy_d;
  logic [PROD_W-1:0]   row_q, row_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [TW-1:0]       fill_q, fill_d;
  logic [NFW-1:0]      next_free_q, next_free_d;
  logic                done_q, done_d;
  sct_pkg::rsp_t       rsp_q, rsp_d;

  sct_pkg::cfg_t       cfg;
  logic                clearing;
  logic                accept;

  logic                tbl_re, tbl_we;
  logic [SW:0]         tbl_wdata, tbl_rdata;
  logic                tbl_valid;
  logic [SW-1:0]       tbl_slot;

  logic                pool_re, pool_we;
  logic [PAW-1:0]      pool_addr;
  logic [TILE_BITS-1:0] pool_wdata, pool_rdata;

  logic [sct_pkg::COORD_W-1:0] cx_w, cy_w;
  logic [TW-1:0]               tile_w;
  logic [TILE_BITS-1:0]        wval_w;
  logic [CNT_W+PROD_W-1:0]     zmul_w;

  sct_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sct_chunk_table #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .SW         (SW),
    .CIW        (CIW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .re_i       (tbl_re),
    .we_i       (tbl_we),
    .addr_i     (idx_q[CIW-1:0]),
    .wdata_i    (tbl_wdata),
    .rdata_o    (tbl_rdata),
    .clearing_o (clearing)
  );

  sct_tile_pool #(
    .DEPTH     (PDEPTH),
    .AW        (PAW),
    .TILE_BITS (TILE_BITS)
  ) u_pool (
    .clk_i   (clk_i),
    .re_i    (pool_re),
    .we_i    (pool_we),
    .addr_i  (pool_addr),
    .wdata_i (pool_wdata),
    .rdata_o (pool_rdata)
  );

  // Split coordinates into chunk and tile-in-chunk parts
  assign cx_w      = req_q.abs_x >> CHUNK_SHIFT;
  assign cy_w      = req_q.abs_y >> CHUNK_SHIFT;
  assign tile_w    = {req_q.abs_y[CHUNK_SHIFT-1:0], req_q.abs_x[CHUNK_SHIFT-1:0]};
  assign wval_w    = TILE_BITS'(req_q.value);
  assign zmul_w    = req_q.abs_z[CNT_W-1:0] * prod_xy_q;
  assign tbl_valid = tbl_rdata[SW];
  assign tbl_slot  = tbl_rdata[SW-1:0];

  assign busy   = (state_q != S_IDLE) || clearing;
  assign accept = start && !busy;

  // Sequence one item through range check, table lookup and pool access
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    range_d     = range_q;
    prod_xy_d   = prod_xy_q;
    row_d       = row_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    next_free_d = next_free_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    tbl_re      = 1'b0;
    tbl_we      = 1'b0;
    tbl_wdata   = {1'b1, SW'(next_free_q)};
    pool_re     = 1'b0;
    pool_we     = 1'b0;
    pool_addr   = {tbl_slot, tile_w};
    pool_wdata  = wval_w;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = req_i;
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        range_d   = (cx_w < sct_pkg::COORD_W'(cfg.cnt_x))
                 && (cy_w < sct_pkg::COORD_W'(cfg.cnt_y))
                 && (req_q.abs_z < sct_pkg::COORD_W'(cfg.cnt_z));
        prod_xy_d = cfg.cnt_y * cfg.cnt_x;
        row_d     = cy_w[CNT_W-1:0] * cfg.cnt_x;
        state_d   = S_IDX;
      end

      S_IDX: begin
        idx_d   = IDX_W'(zmul_w) + IDX_W'(row_q) + IDX_W'(cx_w[CNT_W-1:0]);
        state_d = S_LOOK;
      end

      S_LOOK: begin
        if (!range_q || (idx_q >= IDX_W'(MAX_CHUNKS))) begin
          done_d           = 1'b1;
          rsp_d.tile_value = '0;
          rsp_d.is_empty   = 1'b0;
          rsp_d.status     = sct_pkg::STATUS_RANGE;
          state_d          = S_IDLE;
        end else begin
          tbl_re  = 1'b1;
          state_d = S_TBL;
        end
      end

      S_TBL: begin
        rsp_d.status = sct_pkg::STATUS_OK;
        if (req_q.action == sct_pkg::ACT_READ) begin
          if (tbl_valid) begin
            pool_re = 1'b1;
            state_d = S_POOL;
          end else begin
            done_d           = 1'b1;
            rsp_d.tile_value = '0;
            rsp_d.is_empty   = 1'b0;
            state_d          = S_IDLE;
          end
        end else if (tbl_valid) begin
          // Chunk present: store the tile
          pool_we          = 1'b1;
          done_d           = 1'b1;
          rsp_d.tile_value = sct_pkg::VALUE_W'(wval_w);
          rsp_d.is_empty   = sct_pkg::empty_flag(sct_pkg::VALUE_W'(wval_w));
          state_d          = S_IDLE;
        end else if (next_free_q >= NFW'(POOL_SLOTS)) begin
          // Pool exhausted: drop the write
          done_d           = 1'b1;
          rsp_d.tile_value = '0;
          rsp_d.is_empty   = 1'b0;
          rsp_d.status     = sct_pkg::STATUS_FULL;
          state_d          = S_IDLE;
        end else begin
          // Allocate the next slot, then fill it
          tbl_we      = 1'b1;
          slot_d      = SW'(next_free_q);
          next_free_d = next_free_q + 1'b1;
          fill_d      = '0;
          state_d     = S_FILL;
        end
      end

      S_POOL: begin
        done_d           = 1'b1;
        rsp_d.tile_value = sct_pkg::VALUE_W'(pool_rdata);
        rsp_d.is_empty   = sct_pkg::empty_flag(sct_pkg::VALUE_W'(pool_rdata));
        rsp_d.status     = sct_pkg::STATUS_OK;
        state_d          = S_IDLE;
      end

      S_FILL: begin
        // Write 1 to every tile, the item's own value at its tile
        pool_we    = 1'b1;
        pool_addr  = {slot_q, fill_q};
        pool_wdata = (fill_q == tile_w) ? wval_w : TILE_BITS'(sct_pkg::FILL_VAL);
        fill_d     = fill_q + 1'b1;
        if (&fill_q) begin
          done_d           = 1'b1;
          rsp_d.tile_value = sct_pkg::VALUE_W'(wval_w);
          rsp_d.is_empty   = sct_pkg::empty_flag(sct_pkg::VALUE_W'(wval_w));
          rsp_d.status     = sct_pkg::STATUS_OK;
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, datapath registers and the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      range_q     <= 1'b0;
      prod_xy_q   <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      next_free_q <= '0;
      done_q      <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      range_q     <= range_d;
      prod_xy_q   <= prod_xy_d;
      row_q       <= row_d;
      idx_q       <= idx_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      next_free_q <= next_free_d;
      done_q      <= done_d;
      rsp_q       <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // No result in the cycle right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> !done_o)
    else $error("result strobe right after accept");

  // Slot allocation never passes the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      next_free_q <= NFW'(POOL_SLOTS))
    else $error("free slot counter overran the pool");

  // Pool-exhausted status only with every slot taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && (rsp_o.status == sct_pkg::STATUS_FULL))
      |-> (next_free_q == NFW'(POOL_SLOTS)))
    else $error("pool exhausted reported with free slots");

  // A failed item returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && (rsp_o.status != sct_pkg::STATUS_OK)) |-> (rsp_o.tile_value == '0))
    else $error("nonzero value on a failed item");

  // No item is taken while the chunk table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> busy)
    else $error("not busy during table clear");

endmodule

`default_nettype wire

// File: rtl/sct_cfg.sv
// APB register block holding the chunk counts.
`timescale 1ns / 1ps
`default_nettype none

module sct_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sct_pkg::APB_AW-1:0]   paddr,
  input  wire logic [sct_pkg::APB_DW-1:0]   pwdata,
  output logic      [sct_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output sct_pkg::cfg_t                     cfg_o
);

  sct_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        sct_pkg::REG_CNT_X: cfg_d.cnt_x = pwdata[sct_pkg::CNT_W-1:0];
        sct_pkg::REG_CNT_Y: cfg_d.cnt_y = pwdata[sct_pkg::CNT_W-1:0];
        sct_pkg::REG_CNT_Z: cfg_d.cnt_z = pwdata[sct_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cnt_x <= sct_pkg::CNT_X_RST;
      cfg_q.cnt_y <= sct_pkg::CNT_Y_RST;
      cfg_q.cnt_z <= sct_pkg::CNT_Z_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      sct_pkg::REG_CNT_X: prdata = sct_pkg::APB_DW'(cfg_q.cnt_x);
      sct_pkg::REG_CNT_Y: prdata = sct_pkg::APB_DW'(cfg_q.cnt_y);
      sct_pkg::REG_CNT_Z: prdata = sct_pkg::APB_DW'(cfg_q.cnt_z);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/sct_chunk_table.sv
// Chunk slot table memory with a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sct_chunk_table #(
  parameter int MAX_CHUNKS = sct_pkg::MAX_CHUNKS_DEF,
  parameter int SW         = 6,
  parameter int CIW        = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           re_i,
  input  wire logic           we_i,
  input  wire logic [CIW-1:0] addr_i,
  input  wire logic [SW:0]    wdata_i,
  output logic      [SW:0]    rdata_o,
  output logic                clearing_o
);

  logic [SW:0]    mem [MAX_CHUNKS];
  logic [SW:0]    rdata_q;
  logic           clearing_q;
  logic [CIW-1:0] clr_ptr_q;

  // Sweep every entry to unallocated, one a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_ptr_q  <= '0;
    end else if (clearing_q) begin
      clr_ptr_q <= clr_ptr_q + 1'b1;
      if (clr_ptr_q == CIW'(MAX_CHUNKS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Registered read at addr_i; writes go to the clear pointer during the sweep, else to addr_i
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_ptr_q] <= '0;
    end else if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

`default_nettype wire

// File: rtl/sct_tile_pool.sv
// Tile pool memory, one tile per entry, registered read.
`timescale 1ns / 1ps
`default_nettype none

module sct_tile_pool #(
  parameter int DEPTH     = 16384,
  parameter int AW        = 14,
  parameter int TILE_BITS = sct_pkg::TILE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 re_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        addr_i,
  input  wire logic [TILE_BITS-1:0] wdata_i,
  output logic      [TILE_BITS-1:0] rdata_o
);

  logic [TILE_BITS-1:0] mem [DEPTH];
  logic [TILE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the sparse chunked tile store.
`timescale 1ns / 1ps

module testbench;
  import sct_pkg::*;

  localparam int SHIFT          = CHUNK_SHIFT_DEF;
  localparam int DIM            = 1 << SHIFT;
  localparam int TILES          = DIM * DIM;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int PHASE_ITEMS    = 75;
  localparam int PHASES         = 8;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t want;
  } dir_row_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  req_t               req_i   = '0;
  logic               done_o;
  rsp_t               rsp_o;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [APB_AW-1:0]  paddr   = '0;
  logic [APB_DW-1:0]  pwdata  = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  // Shadow of the tile map
  cfg_t               counts;
  bit                 chunk_live [MAX_CHUNKS_DEF];
  int unsigned        chunk_slot [MAX_CHUNKS_DEF];
  logic [VALUE_W-1:0] pool_tiles [POOL_SLOTS_DEF*TILES];
  int unsigned        slots_taken;

  rsp_t               expected_tiles [$];
  dir_row_t           dir_rows [$];
  int unsigned        mismatches;
  int unsigned        quiet_cycles;
  bit                 idle_gaps;

  sparse_chunked_tile_store dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Work out the result of one tile access and advance the shadow map
  function automatic rsp_t predict_tile_access(input req_t r);
    rsp_t              res;
    longint unsigned   cx;
    longint unsigned   cy;
    longint unsigned   cz;
    longint unsigned   idx;
    int unsigned       tile;
    int unsigned       t;
    bit                hit;
    res  = '0;
    cx   = r.abs_x >> SHIFT;
    cy   = r.abs_y >> SHIFT;
    cz   = r.abs_z;
    tile = ((r.abs_y % DIM) << SHIFT) | (r.abs_x % DIM);
    hit  = cx < counts.cnt_x && cy < counts.cnt_y && cz < counts.cnt_z;
    idx  = cz * counts.cnt_y * counts.cnt_x + cy * counts.cnt_x + cx;
    if (!hit || idx >= MAX_CHUNKS_DEF) begin
      res.status = STATUS_RANGE;
    end else if (r.action == ACT_READ) begin
      if (chunk_live[idx]) res.tile_value = pool_tiles[chunk_slot[idx]*TILES + tile];
    end else begin
      // Take a fresh slot on the first write to a chunk
      if (!chunk_live[idx]) begin
        if (slots_taken >= POOL_SLOTS_DEF) begin
          res.status = STATUS_FULL;
        end else begin
          for (t = 0; t < TILES; t++) begin
            pool_tiles[slots_taken*TILES + t] = VALUE_W'(FILL_VAL);
          end
          chunk_slot[idx] = slots_taken;
          chunk_live[idx] = 1'b1;
          slots_taken++;
        end
      end
      if (res.status == STATUS_OK) begin
        pool_tiles[chunk_slot[idx]*TILES + tile] = r.value;
        res.tile_value = r.value;
      end
    end
    res.is_empty = (res.tile_value == EMPTY_VAL_A) || (res.tile_value == EMPTY_VAL_B) ||
                   (res.tile_value == EMPTY_VAL_C);
    return res;
  endfunction

  // Chunk coordinate: mostly near the origin, sometimes anywhere or one past the end
  function automatic logic [COORD_W-1:0] pick_chunk(input int unsigned count);
    int unsigned c;
    case ($urandom_range(0, 9))
      0: c = count;
      1, 2: c = (count == 0) ? 0 : $urandom_range(0, count - 1);
      default: c = $urandom_range(0, ((count > 6) ? 6 : ((count == 0) ? 1 : count)) - 1);
    endcase
    return c;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.action = 1'($urandom_range(0, 1));
    r.value  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 5)) : 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      r.abs_x = $urandom;
      r.abs_y = $urandom;
      r.abs_z = $urandom;
    end else begin
      r.abs_x = (pick_chunk(counts.cnt_x) << SHIFT) | $urandom_range(0, DIM - 1);
      r.abs_y = (pick_chunk(counts.cnt_y) << SHIFT) | $urandom_range(0, DIM - 1);
      r.abs_z = pick_chunk(counts.cnt_z);
    end
    return r;
  endfunction

  function automatic void add_row(input logic act, input logic [31:0] x, y, z,
                                  input logic [15:0] v, input logic typed,
                                  input logic [15:0] tv, input logic em,
                                  input logic [1:0] st);
    dir_rows.push_back({act, x, y, z, v, typed, tv, em, st});
  endfunction

  // Offer one item from a falling edge; return at the falling edge after it is taken
  task automatic send_item(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    if (idle_gaps && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred = predict_tile_access(r);
    expected_tiles.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  // Drop start and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    while (expected_tiles.size() != 0) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {19'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_CNT_X: counts.cnt_x = val;
      REG_CNT_Y: counts.cnt_y = val;
      REG_CNT_Z: counts.cnt_z = val;
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [CNT_W-1:0] want);
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    if (got[CNT_W-1:0] !== want) begin
      mismatches++;
      $display("%0t: register %0d expected %0d got %0d", $time, idx, want, got[CNT_W-1:0]);
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_tiles.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got %h", $time, rsp_o);
      end else begin
        want = expected_tiles.pop_front();
        if (rsp_o.tile_value !== want.tile_value) begin
          mismatches++;
          $display("%0t: tile_value expected %h got %h", $time, want.tile_value,
                   rsp_o.tile_value);
        end
        if (rsp_o.is_empty !== want.is_empty) begin
          mismatches++;
          $display("%0t: is_empty expected %b got %b", $time, want.is_empty, rsp_o.is_empty);
        end
        if (rsp_o.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp_o.status);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int       ph;
    int       k;
    int       spare;
    req_t     wreq;
    req_t     rreq;
    dir_row_t row;
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;
    logic [CNT_W-1:0] nz;

    counts       = '{cnt_x: CNT_X_RST, cnt_y: CNT_Y_RST, cnt_z: CNT_Z_RST};
    slots_taken  = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    idle_gaps    = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset counts (16 x 16 x 1)
    add_row(ACT_READ,  32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 16'h0, 1'b0, STATUS_OK);
    add_row(ACT_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,
            1'b1, 16'h0, 1'b0, STATUS_RANGE);
    add_row(ACT_WRITE, 32'h100, 32'h0, 32'h0, 16'hFFFF, 1'b1, 16'h0, 1'b0, STATUS_RANGE);
    add_row(ACT_WRITE, 32'h0, 32'h100, 32'h0, 16'hFFFF, 1'b1, 16'h0, 1'b0, STATUS_RANGE);
    add_row(ACT_WRITE, 32'h0, 32'h0, 32'h1, 16'hFFFF, 1'b1, 16'h0, 1'b0, STATUS_RANGE);
    add_row(ACT_READ,  32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 16'h0, 1'b0, STATUS_OK);
    add_row(ACT_WRITE, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, STATUS_OK);
    add_row(ACT_READ,  32'h1, 32'h0, 32'h0, 16'h0, 1'b1, 16'h1, 1'b1, STATUS_OK);
    add_row(ACT_READ,  32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 16'hFFFF, 1'b0, STATUS_OK);
    add_row(ACT_WRITE, 32'hF, 32'hF, 32'h0, 16'h3, 1'b1, 16'h3, 1'b1, STATUS_OK);
    add_row(ACT_WRITE, 32'hE, 32'hF, 32'h0, 16'h4, 1'b1, 16'h4, 1'b1, STATUS_OK);
    add_row(ACT_WRITE, 32'hD, 32'hF, 32'h0, 16'h1, 1'b1, 16'h1, 1'b1, STATUS_OK);
    add_row(ACT_WRITE, 32'hC, 32'hF, 32'h0, 16'h0, 1'b1, 16'h0, 1'b0, STATUS_OK);
    add_row(ACT_WRITE, 32'hB, 32'hF, 32'h0, 16'h2, 1'b1, 16'h2, 1'b0, STATUS_OK);
    add_row(ACT_READ,  32'hF, 32'hF, 32'h0, 16'h0, 1'b1, 16'h3, 1'b1, STATUS_OK);
    add_row(ACT_WRITE, 32'hFF, 32'hFF, 32'h0, 16'h5A5A, 1'b1, 16'h5A5A, 1'b0, STATUS_OK);
    add_row(ACT_READ,  32'hF0, 32'hFF, 32'h0, 16'h0, 1'b1, 16'h1, 1'b1, STATUS_OK);
    add_row(ACT_READ,  32'h0, 32'h10, 32'h0, 16'h0, 1'b1, 16'h0, 1'b0, STATUS_OK);
    add_row(ACT_READ,  32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 16'h0,
            1'b1, 16'h0, 1'b0, STATUS_RANGE);
    add_row(ACT_WRITE, 32'hF, 32'h0, 32'h8000_0000, 16'h1234,
            1'b1, 16'h0, 1'b0, STATUS_RANGE);
    add_row(ACT_WRITE, 32'h37, 32'hC9, 32'h0, 16'($urandom), 1'b0, 16'h0, 1'b0, STATUS_OK);
    add_row(ACT_READ,  32'h37, 32'hC9, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0, STATUS_OK);
    add_row(ACT_READ,  32'h38, 32'hC9, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0, STATUS_OK);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.req, row.typed, row.want);
    end

    // Random phases, each under its own chunk counts
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        1: begin nx = 13'd4;    ny = 13'd4;    nz = 13'd4;    end
        2: begin nx = 13'd4096; ny = 13'd4096; nz = 13'd4096; end
        3: begin nx = 13'd16;   ny = 13'd16;   nz = 13'd1;    end
        4: begin nx = 13'd0;    ny = 13'd5;    nz = 13'd3;    end
        5: begin nx = 13'd8191; ny = 13'd2;    nz = 13'd1;    end
        6: begin nx = 13'd1;    ny = 13'd1;    nz = 13'd1;    end
        7: begin nx = 13'd64;   ny = 13'd8;    nz = 13'd8;    end
        default: begin nx = counts.cnt_x; ny = counts.cnt_y; nz = counts.cnt_z; end
      endcase
      if (ph != 0) begin
        reg_write(REG_CNT_X, nx);
        reg_write(REG_CNT_Y, ny);
        reg_write(REG_CNT_Z, nz);
        reg_write(REG_SPARE, 13'($urandom));
      end
      reg_check(REG_CNT_X, counts.cnt_x);
      reg_check(REG_CNT_Y, counts.cnt_y);
      reg_check(REG_CNT_Z, counts.cnt_z);
      idle_gaps = (ph < PHASES - 2);

      // Walk the chunks in order past the point where the pool runs dry, a random read after each write
      if (ph == 3) begin
        spare = 0;
        for (k = 0; k < TILES && spare < 6; k++) begin
          wreq.action = ACT_WRITE;
          wreq.abs_x  = ((k % DIM) << SHIFT) | $urandom_range(0, DIM - 1);
          wreq.abs_y  = ((k / DIM) << SHIFT) | $urandom_range(0, DIM - 1);
          wreq.abs_z  = '0;
          wreq.value  = 16'($urandom);
          send_item(wreq, 1'b0, '0);
          if (slots_taken >= POOL_SLOTS_DEF) spare++;
          rreq = random_request();
          rreq.action = ACT_READ;
          send_item(rreq, 1'b0, '0);
        end
      end
      repeat (PHASE_ITEMS) send_item(random_request(), 1'b0, '0);
    end

    // Drain and report
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sct_pkg.sv
rtl/sct_cfg.sv
rtl/sct_chunk_table.sv
rtl/sct_tile_pool.sv
rtl/sparse_chunked_tile_store.sv
sim/testbench.sv
